### rtl/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg: slot pool allocator shared definitions
// Table size, field widths, request kinds and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package spa_pkg;

  // table geometry and time base
  localparam int POOL_SLOTS = 16;
  localparam int TIME_BITS  = 32;
  localparam int SLOT_W     = $clog2(POOL_SLOTS);
  localparam int CNT_W      = $clog2(POOL_SLOTS + 1);

  // reset value of the idle timeout, in seconds
  localparam logic [TIME_BITS-1:0] TIMEOUT_RESET = TIME_BITS'(60);

  // request kinds
  typedef enum logic [1:0] {
    KIND_ACQUIRE = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_FLUSH   = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [2:0] {
    STAT_REUSED    = 3'd0,
    STAT_NEW       = 3'd1,
    STAT_UNPOOLED  = 3'd2,
    STAT_RETURNED  = 3'd3,
    STAT_DESTROYED = 3'd4,
    STAT_FLUSHED   = 3'd5
  } status_t;

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_FLUSH = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

endpackage : spa_pkg

`default_nettype wire

### rtl/slot_pool_allocator_idle_timeout_top.sv
// ----------------------------------------------------------------------------
// slot_pool_allocator_idle_timeout_top: resource slot pool with idle timeout
// Sixteen-slot table with occupied/busy marks and last-use stamps; acquire,
// release and flush requests, one result beat per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_* stream (kind in s_tuser, time, slot and pooled
//   flag in s_tdata); each request of kind acquire, release or flush yields
//   one result beat on m_* (status in m_tuser, slot and evict count in
//   m_tdata). Kind 3 is dropped without a result.
//   cfg_we/cfg_data write the idle timeout; write only while idle.
// Timing:
//   One request at a time; s_tready is low while a request is in work.
//   Release: goes straight to the done state, then to the output register.
//   Acquire: one slot per cycle through a single age subtract-and-compare
//   unit; a reused slot ends the scan early, else the scan runs to the last
//   slot before the done state.
//   Flush of a ready pool walks all slots to count them; flush of an empty
//   pool goes straight to the done state.
// Reset / stall:
//   rst (synchronous) empties the table and sets the timeout to 60 s.
//   Results sit in an output register; a new request is accepted while a
//   result waits, and its own result holds in the sequencer until the
//   output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_pool_allocator_idle_timeout_top
  import spa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration: idle timeout in seconds
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // now[31:0], slot_id[35:32], is_pooled[36], zero pad
  input  wire logic [1:0]  s_tuser,   // kind[1:0]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // granted_slot[3:0], evicted_count[8:4], zero pad
  output logic [2:0]       m_tuser    // status[2:0]
);

  // slot table
  logic [POOL_SLOTS-1:0] occupied;
  logic [POOL_SLOTS-1:0] busy;
  logic [TIME_BITS-1:0]  stamp [POOL_SLOTS];
  logic                  pool_ready;
  logic [31:0]           idle_timeout;

  // sequencer and working registers
  state_t                state;
  logic [SLOT_W-1:0]     idx;
  logic [TIME_BITS-1:0]  now_r;
  logic                  have_free;
  logic [SLOT_W-1:0]     free_idx;
  status_t               res_status;
  logic [SLOT_W-1:0]     res_slot;
  logic [CNT_W-1:0]      res_count;

  // request fields
  kind_t                 in_kind;
  logic [TIME_BITS-1:0]  in_now;
  logic [3:0]            in_sid;
  logic                  in_pooled;
  logic                  s_fire;

  assign in_kind   = kind_t'(s_tuser);
  assign in_now    = s_tdata[31:0];
  assign in_sid    = s_tdata[35:32];
  assign in_pooled = s_tdata[36];
  assign s_tready  = (state == S_IDLE);
  assign s_fire    = s_tvalid && s_tready;

  // shared age unit: modular age of the slot under the scan pointer
  logic [TIME_BITS-1:0] age;
  logic                 cand;
  logic                 expired;
  logic                 free_hit;
  logic [SLOT_W-1:0]    free_sel;
  logic                 last;
  logic                 out_free;

  assign age      = now_r - stamp[idx];
  assign cand     = occupied[idx] && !busy[idx];
  assign expired  = cand && (age >= idle_timeout);
  assign free_hit = !have_free && (!occupied[idx] || expired);
  assign free_sel = have_free ? free_idx : idx;
  assign last     = (idx == SLOT_W'(POOL_SLOTS - 1));
  assign out_free = !m_tvalid || m_tready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      idle_timeout <= cfg_data;
    end
  end

  // sequencer, table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      occupied   <= '0;
      busy       <= '0;
      pool_ready <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_fire) begin
            idx       <= '0;
            now_r     <= in_now;
            res_slot  <= '0;
            res_count <= '0;
            have_free <= 1'b0;
            unique case (in_kind)
              KIND_ACQUIRE: begin
                // first acquire after reset or flush starts from a clean table;
                // stamps are always written before they are read
                if (!pool_ready) begin
                  occupied   <= '0;
                  busy       <= '0;
                  pool_ready <= 1'b1;
                end
                state <= S_SCAN;
              end
              KIND_RELEASE: begin
                res_status <= STAT_DESTROYED;
                if (pool_ready && in_pooled && (int'(in_sid) < POOL_SLOTS) &&
                    occupied[in_sid[SLOT_W-1:0]]) begin
                  busy[in_sid[SLOT_W-1:0]]  <= 1'b0;
                  stamp[in_sid[SLOT_W-1:0]] <= in_now;
                  res_status                <= STAT_RETURNED;
                end
                state <= S_DONE;
              end
              KIND_FLUSH: begin
                res_status <= STAT_FLUSHED;
                state      <= pool_ready ? S_FLUSH : S_DONE;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (cand && !expired) begin
            // fresh idle slot: reuse it and stop
            busy[idx]  <= 1'b1;
            stamp[idx] <= now_r;
            res_status <= STAT_REUSED;
            res_slot   <= idx;
            state      <= S_DONE;
          end else begin
            if (expired) begin
              // an expired last slot that becomes the grant stays occupied
              if (!(last && !have_free)) begin
                occupied[idx] <= 1'b0;
              end
              res_count <= res_count + CNT_W'(1);
            end
            if (free_hit) begin
              have_free <= 1'b1;
              free_idx  <= idx;
            end
            if (last) begin
              // no reuse: take the first empty or evicted slot, else unpooled
              if (have_free || free_hit) begin
                occupied[free_sel] <= 1'b1;
                busy[free_sel]     <= 1'b1;
                stamp[free_sel]    <= now_r;
                res_status         <= STAT_NEW;
                res_slot           <= free_sel;
              end else begin
                res_status <= STAT_UNPOOLED;
                res_slot   <= '0;
              end
              state <= S_DONE;
            end else begin
              idx <= idx + SLOT_W'(1);
            end
          end
        end

        S_FLUSH: begin
          // count and free occupied slots one per cycle
          if (occupied[idx]) begin
            occupied[idx] <= 1'b0;
            res_count     <= res_count + CNT_W'(1);
          end
          if (last) begin
            pool_ready <= 1'b0;
            state      <= S_DONE;
          end else begin
            idx <= idx + SLOT_W'(1);
          end
        end

        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if ((state == S_DONE) && out_free) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      m_tuser <= res_status;
      m_tdata <= {7'd0, res_count, 4'(res_slot)};
    end
  end

  // ---- assertions ----
  // an acquire always leaves the pool ready
  a_ready_after_acquire: assert property (@(posedge clk) disable iff (rst)
    s_fire && (in_kind == KIND_ACQUIRE) |=> pool_ready)
    else $error("pool not ready after acquire");

  // evict count never exceeds the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[8:4] <= CNT_W'(POOL_SLOTS)))
    else $error("evict count out of range");

  // only grants carry a slot number
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != STAT_REUSED) && (m_tuser != STAT_NEW)
      |-> (m_tdata[3:0] == 4'd0))
    else $error("slot set on non-grant result");

  // scan count cannot pass the scan pointer
  a_scan_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (res_count <= CNT_W'(idx)))
    else $error("evict count ahead of scan");

endmodule : slot_pool_allocator_idle_timeout_top

`default_nettype wire

### tb/sv/slot_pool_allocator_idle_timeout_top_test.sv
// ----------------------------------------------------------------------------
// slot_pool_allocator_idle_timeout_top_test: slot pool allocator testbench
// A short scripted sequence covers the table corner cases: release and flush
// before the first acquire, reuse, timeout eviction, time wrap, a full table
// and a flush of a full table. Random traffic follows under several idle
// timeouts, 0 and all ones among them. Every result beat is checked against
// an in-bench model of the slot table, with random request gaps, random
// result back-pressure and one long result stall that backs up the block.
// ----------------------------------------------------------------------------
module slot_pool_allocator_idle_timeout_top_test;
  import spa_pkg::*;

  localparam int NSLOT        = 16;
  localparam int SETTLE_CYC   = 24;  // covers the longest request, a full scan or flush walk
  localparam int PHASE_ITEMS  = 100;
  localparam int HOLD_CYC     = 400;
  localparam int SCRIPT_LEN   = 19;

  // one result beat
  typedef struct packed {
    status_t    status;
    logic [3:0] slot;
    logic [4:0] evicted;
  } pool_answer_t;

  // one scripted request; answer fields are used only when fixed is set
  typedef struct packed {
    kind_t       kind;
    logic [31:0] now;
    logic [3:0]  sid;
    logic        pooled;
    logic [4:0]  reps;
    bit          fixed;
    status_t     status;
    logic [3:0]  slot;
    logic [4:0]  evicted;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;   // now[31:0], slot_id[35:32], is_pooled[36], zero pad
  logic [1:0]  s_tuser = '0;   // kind[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // granted_slot[3:0], evicted_count[8:4], zero pad
  logic [2:0]  m_tuser;        // status[2:0]

  // slot table model
  logic        slot_taken  [NSLOT];
  logic        slot_lent   [NSLOT];
  logic [31:0] slot_used_at[NSLOT];
  logic        table_live;
  logic [31:0] idle_limit;

  pool_answer_t pending_answers[$];
  script_row_t  script[SCRIPT_LEN];
  int           errors = 0;
  int           burst_left = 0;
  logic [31:0]  wall_clock;
  bit           random_on = 1'b0;
  logic         rx_hold = 1'b0;
  int           rx_mode = 0;

  slot_pool_allocator_idle_timeout_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  initial begin
    #2000000;
    $display("slot_pool_allocator_idle_timeout_top regression: fail");
    $finish;
  end

  // empty every slot
  function automatic void wipe_table();
    for (int i = 0; i < NSLOT; i++) begin
      slot_taken[i]   = 1'b0;
      slot_lent[i]    = 1'b0;
      slot_used_at[i] = '0;
    end
  endfunction

  // advance the table model by one request; returns 0 when no beat follows
  function automatic bit pool_predict(input kind_t k, input logic [31:0] now,
                                      input logic [3:0] sid, input logic pooled,
                                      output pool_answer_t ans);
    bit          done;
    logic [31:0] age;
    ans = '{status: STAT_UNPOOLED, slot: 4'd0, evicted: 5'd0};
    done = 1'b0;
    case (k)
      KIND_ACQUIRE: begin
        if (!table_live) begin
          wipe_table();
          table_live = 1'b1;
        end
        // age out stale idle slots until a fresh one is found
        for (int i = 0; i < NSLOT; i++) begin
          if (!done && slot_taken[i] && !slot_lent[i]) begin
            age = now - slot_used_at[i];
            if (age >= idle_limit) begin
              slot_taken[i] = 1'b0;
              ans.evicted   = ans.evicted + 5'd1;
            end else begin
              slot_lent[i]    = 1'b1;
              slot_used_at[i] = now;
              ans.status      = STAT_REUSED;
              ans.slot        = 4'(i);
              done            = 1'b1;
            end
          end
        end
        // otherwise take the first empty slot
        for (int i = 0; i < NSLOT; i++) begin
          if (!done && !slot_taken[i]) begin
            slot_taken[i]   = 1'b1;
            slot_lent[i]    = 1'b1;
            slot_used_at[i] = now;
            ans.status      = STAT_NEW;
            ans.slot        = 4'(i);
            done            = 1'b1;
          end
        end
        return 1'b1;
      end
      KIND_RELEASE: begin
        ans.status = STAT_DESTROYED;
        if (table_live && pooled && slot_taken[sid]) begin
          slot_lent[sid]    = 1'b0;
          slot_used_at[sid] = now;
          ans.status        = STAT_RETURNED;
        end
        return 1'b1;
      end
      KIND_FLUSH: begin
        ans.status = STAT_FLUSHED;
        if (table_live) begin
          for (int i = 0; i < NSLOT; i++) begin
            if (slot_taken[i]) begin
              slot_taken[i] = 1'b0;
              ans.evicted   = ans.evicted + 5'd1;
            end
          end
          table_live = 1'b0;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // offer one request beat and log its answer once it is taken
  task automatic offer(input kind_t k, input logic [31:0] now, input logic [3:0] sid,
                       input logic pooled, input bit fixed, input pool_answer_t want);
    pool_answer_t ans;
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, pooled, sid, now};
    s_tuser  <= k;
    do @(posedge clk); while (!s_tready);
    if (pool_predict(k, now, sid, pooled, ans))
      pending_answers.push_back(fixed ? want : ans);
  endtask

  // drop valid, wait for every answer, then let a late request finish
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_idle_limit(input logic [31:0] v);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    idle_limit = v;
  endtask

  // sender pacing: bursts of random length, random gaps between them
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
  endtask

  // one random request; releases mostly target slots that are in use
  task automatic random_request();
    int           sel;
    kind_t        k;
    logic [3:0]   sid;
    logic         pooled;
    int           in_use[$];
    pool_answer_t none;
    none = '0;
    case ($urandom_range(0, 9))
      0:       wall_clock = wall_clock + $urandom();
      1:       wall_clock = $urandom();
      default: wall_clock = wall_clock + $urandom_range(0, 40);
    endcase
    sel    = $urandom_range(0, 99);
    sid    = 4'($urandom_range(0, 15));
    pooled = ($urandom_range(0, 9) != 0);
    if (sel < 47)      k = KIND_ACQUIRE;
    else if (sel < 93) k = KIND_RELEASE;
    else if (sel < 98) k = KIND_FLUSH;
    else               k = KIND_NONE;
    if (k == KIND_RELEASE && $urandom_range(0, 4) != 0) begin
      for (int i = 0; i < NSLOT; i++)
        if (slot_taken[i]) in_use.push_back(i);
      if (in_use.size() != 0)
        sid = 4'(in_use[$urandom_range(0, in_use.size() - 1)]);
    end
    pace();
    offer(k, wall_clock, sid, pooled, 1'b0, none);
  endtask

  // compare one field of a result beat
  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // result side: check accepted beats, drive back-pressure
  always @(posedge clk) begin
    pool_answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected beat, actual status %0d slot %0d evicted %0d",
                 $time, m_tuser, m_tdata[3:0], m_tdata[8:4]);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        check_field("status", want.status, m_tuser);
        check_field("granted_slot", want.slot, m_tdata[3:0]);
        check_field("evicted_count", want.evicted, m_tdata[8:4]);
      end
    end
    if ($urandom_range(0, 63) == 0) rx_mode <= $urandom_range(0, 3);
    m_tready <= !rx_hold && (rx_mode == 0 || $urandom_range(0, rx_mode) == 0);
  end

  // one long result stall while requests keep coming
  initial begin
    wait (random_on);
    repeat ($urandom_range(20, 80)) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // stimulus
  initial begin
    logic [31:0] limits[5];
    pool_answer_t want;

    // scripted requests, timeout at its reset value of 60
    script = '{
      // release and flush before the first acquire
      '{KIND_RELEASE, 32'd0, 4'd0, 1'b1, 5'd1, 1'b1, STAT_DESTROYED, 4'd0, 5'd0},
      '{KIND_FLUSH, 32'd0, 4'd0, 1'b0, 5'd1, 1'b1, STAT_FLUSHED, 4'd0, 5'd0},
      '{KIND_ACQUIRE, 32'd100, 4'd0, 1'b0, 5'd1, 1'b1, STAT_NEW, 4'd0, 5'd0},
      '{KIND_ACQUIRE, 32'd100, 4'd0, 1'b0, 5'd1, 1'b1, STAT_NEW, 4'd1, 5'd0},
      // unpooled resource and a slot never used
      '{KIND_RELEASE, 32'd110, 4'd0, 1'b0, 5'd1, 1'b1, STAT_DESTROYED, 4'd0, 5'd0},
      '{KIND_RELEASE, 32'd110, 4'd15, 1'b1, 5'd1, 1'b1, STAT_DESTROYED, 4'd0, 5'd0},
      '{KIND_RELEASE, 32'd110, 4'd0, 1'b1, 5'd1, 1'b1, STAT_RETURNED, 4'd0, 5'd0},
      // age 59 is reused, age 60 is evicted
      '{KIND_ACQUIRE, 32'd169, 4'd0, 1'b0, 5'd1, 1'b1, STAT_REUSED, 4'd0, 5'd0},
      '{KIND_RELEASE, 32'd170, 4'd0, 1'b1, 5'd1, 1'b1, STAT_RETURNED, 4'd0, 5'd0},
      '{KIND_RELEASE, 32'd170, 4'd1, 1'b1, 5'd1, 1'b1, STAT_RETURNED, 4'd0, 5'd0},
      '{KIND_ACQUIRE, 32'd230, 4'd0, 1'b0, 5'd1, 1'b1, STAT_NEW, 4'd0, 5'd2},
      // unused kind gives no beat
      '{KIND_NONE, 32'hFFFF_FFFF, 4'd15, 1'b1, 5'd1, 1'b0, STAT_REUSED, 4'd0, 5'd0},
      '{KIND_FLUSH, 32'd0, 4'd0, 1'b0, 5'd1, 1'b1, STAT_FLUSHED, 4'd0, 5'd1},
      // age across the time wrap
      '{KIND_ACQUIRE, 32'hFFFF_FFFF, 4'd0, 1'b0, 5'd1, 1'b1, STAT_NEW, 4'd0, 5'd0},
      '{KIND_RELEASE, 32'hFFFF_FFFF, 4'd0, 1'b1, 5'd1, 1'b1, STAT_RETURNED, 4'd0, 5'd0},
      '{KIND_ACQUIRE, 32'h0000_003A, 4'd0, 1'b0, 5'd1, 1'b0, STAT_REUSED, 4'd0, 5'd0},
      // fill the table, the last acquire is unpooled, then flush it all
      '{KIND_ACQUIRE, 32'h8000_0000, 4'd0, 1'b0, 5'd16, 1'b0, STAT_REUSED, 4'd0, 5'd0},
      '{KIND_FLUSH, 32'h8000_0001, 4'd0, 1'b0, 5'd1, 1'b1, STAT_FLUSHED, 4'd0, 5'd16},
      '{KIND_FLUSH, 32'h8000_0002, 4'd0, 1'b0, 5'd1, 1'b1, STAT_FLUSHED, 4'd0, 5'd0}
    };
    limits = '{32'd0, 32'd25, 32'hFFFF_FFFF, 32'd1, 32'($urandom_range(2, 200))};

    wipe_table();
    table_live = 1'b0;
    idle_limit = TIMEOUT_RESET;
    wall_clock = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[r]) begin
      want = '{status: script[r].status, slot: script[r].slot, evicted: script[r].evicted};
      repeat (script[r].reps)
        offer(script[r].kind, script[r].now, script[r].sid, script[r].pooled,
              script[r].fixed, want);
    end

    // random traffic, first under the reset timeout, then each new setting
    random_on = 1'b1;
    repeat (PHASE_ITEMS) random_request();
    foreach (limits[p]) begin
      set_idle_limit(limits[p]);
      repeat (PHASE_ITEMS) random_request();
    end

    settle();
    if (errors == 0)
      $display("slot_pool_allocator_idle_timeout_top regression: pass");
    else
      $display("slot_pool_allocator_idle_timeout_top regression: fail");
    $finish;
  end

endmodule
